@@ design/pcdm_pkg.sv @@
// Shared constants, register codes and types for the pot-to-CC deadband mapper.
`timescale 1ns / 1ps

package pcdm_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam int ADC_BITS_DEF = 10;

   localparam int CHAN_W     = 4;
   localparam int SAMPLE_W   = 10;
   localparam int CC_W       = 7;
   localparam int MIDI_CH_W  = 4;
   localparam int THRESH_W   = 10;

   localparam int REQ_W      = 40;
   localparam int RSP_W      = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CC_W-1:0]      CC_MAX       = 7'd127;
   localparam logic [THRESH_W-1:0]  THRESH_RESET = 10'd8;
   localparam logic [MIDI_CH_W-1:0] MIDI_RESET   = 4'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_THRESHOLD = 1'b0,
      REG_MIDI_CHANNEL   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic            hit;
      logic [CC_W-1:0] value;
   } calc_result_type;

endpackage

@@ design/pcdm_store.sv @@
// Per-channel last accepted sample store with valid bits and write forwarding.
`timescale 1ns / 1ps

module pcdm_store #(
   parameter int CHANNELS = pcdm_pkg::CHANNELS_DEF,
   parameter int ADC_BITS = pcdm_pkg::ADC_BITS_DEF,
   parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  logic [ADC_BITS-1:0] wr_data,
   output logic [ADC_BITS-1:0] rd_data
);
   import pcdm_pkg::*;

   logic [ADC_BITS-1:0] store_ff [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [CHANNELS-1:0] valid_in;
   logic [ADC_BITS-1:0] rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Forward a write to the same entry; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_addr]) begin
            rd_data_ff <= store_ff[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/pcdm_calc.sv @@
// Deadband test, optional inversion and linear limit mapping of one sample.
`timescale 1ns / 1ps

module pcdm_calc #(
   parameter int ADC_BITS = pcdm_pkg::ADC_BITS_DEF
) (
   input  logic                          in_range,
   input  logic [ADC_BITS-1:0]           sample,
   input  logic [ADC_BITS-1:0]           old_sample,
   input  logic [pcdm_pkg::THRESH_W-1:0] threshold,
   input  logic                          inverted,
   input  logic [pcdm_pkg::CC_W-1:0]     lower_limit,
   input  logic [pcdm_pkg::CC_W-1:0]     upper_limit,
   output pcdm_pkg::calc_result_type     result
);
   import pcdm_pkg::*;

   localparam int CW = (ADC_BITS > THRESH_W) ? ADC_BITS : THRESH_W;

   logic [CW-1:0]   a_ext;
   logic [CW-1:0]   b_ext;
   logic [CW-1:0]   diff;
   logic            step_ok;
   logic [CC_W-1:0] seven_new;
   logic [CC_W-1:0] seven_old;
   logic [CC_W-1:0] v_inv;
   logic            rising;
   logic [CC_W-1:0] span_mag;
   logic [13:0]     prod;
   logic [14:0]     prod_p1;
   logic [20:0]     recip;
   logic [CC_W-1:0] quot;
   logic [CC_W-1:0] mapped;
   logic            full_range;

   always_comb begin
      a_ext     = CW'(sample);
      b_ext     = CW'(old_sample);
      diff      = (a_ext >= b_ext) ? (a_ext - b_ext) : (b_ext - a_ext);
      step_ok   = (diff >= CW'(threshold));
      seven_new = sample[ADC_BITS-1 -: CC_W];
      seven_old = old_sample[ADC_BITS-1 -: CC_W];
      v_inv     = inverted ? (CC_MAX - seven_new) : seven_new;

      rising    = (upper_limit >= lower_limit);
      span_mag  = rising ? (upper_limit - lower_limit) : (lower_limit - upper_limit);
      prod      = 14'(v_inv) * 14'(span_mag);
      // Exact floor(prod / 127) for prod <= 127*127: ((prod + 1) * 129) >> 14.
      prod_p1   = 15'(prod) + 15'd1;
      recip     = (21'(prod_p1) << 7) + 21'(prod_p1);
      quot      = recip[20:14];
      mapped    = rising ? (lower_limit + quot) : (lower_limit - quot);

      full_range   = (lower_limit == '0) && (upper_limit == CC_MAX);
      result.hit   = in_range && step_ok && (seven_new != seven_old);
      result.value = full_range ? v_inv : mapped;
   end

endmodule

@@ design/pot_to_cc_deadband_mapper_core.sv @@
// Top level of the pot-to-CC deadband mapper: handshakes, pipeline and registers.
`timescale 1ns / 1ps

// Takes one sample beat per cycle and returns at most one control change per
// sample; a result passes from the stage 1 register into the result register
// on rsp, and the block keeps taking one beat per cycle while rsp is free, the
// rate being set by the read-modify-write of the per-channel sample store
// (registered read with forwarding from the write in the same cycle). The
// store comes out of reset cleared by per-entry valid bits, so there is no
// clearing pass. Samples on a channel at or above CHANNELS, within the deadband,
// or with an unchanged 7-bit value are dropped without a result. Configuration
// writes are taken at any time and should only be issued while the block is idle.
module pot_to_cc_deadband_mapper_core #(
   parameter int CHANNELS = pcdm_pkg::CHANNELS_DEF,
   parameter int ADC_BITS = pcdm_pkg::ADC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // channel[3:0], sample[13:4], inverted[14], lower_limit[21:15],
   // upper_limit[28:22], controller_number[35:29], zero[39:36]
   input  logic [pcdm_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cc_controller[6:0], cc_value[13:7], cc_channel[17:14], zero[23:18]
   output logic [pcdm_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pcdm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcdm_pkg::CSR_DATA_W-1:0] csr_data
);
   import pcdm_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [THRESH_W-1:0]  thresh_ff;
   logic [MIDI_CH_W-1:0] midi_ff;

   logic                 req_acc;
   logic                 s1_adv;
   logic                 s1_valid_ff;
   logic [CHAN_W-1:0]    s1_chan_ff;
   logic [ADC_BITS-1:0]  s1_sample_ff;
   logic                 s1_inv_ff;
   logic [CC_W-1:0]      s1_lo_ff;
   logic [CC_W-1:0]      s1_hi_ff;
   logic [CC_W-1:0]      s1_ctl_ff;
   logic                 s1_in_range;
   logic [ADC_BITS-1:0]  old_sample;
   calc_result_type      calc;
   logic                 wr_en;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [CC_W-1:0]      rsp_ctl_ff;
   logic [CC_W-1:0]      rsp_value_ff;
   logic [MIDI_CH_W-1:0] rsp_chan_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         midi_ff   <= MIDI_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_STEP_THRESHOLD: thresh_ff <= csr_data;
            REG_MIDI_CHANNEL:   midi_ff   <= csr_data[MIDI_CH_W-1:0];
            default:            ;
         endcase
      end
   end

   // Pipeline control: stage 1 advances whenever the result register is free
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_chan_ff   <= req_tdata[3:0];
         s1_sample_ff <= ADC_BITS'(req_tdata[13:4]);
         s1_inv_ff    <= req_tdata[14];
         s1_lo_ff     <= req_tdata[21:15];
         s1_hi_ff     <= req_tdata[28:22];
         s1_ctl_ff    <= req_tdata[35:29];
      end
   end

   assign s1_in_range = (32'(s1_chan_ff) < 32'(CHANNELS));
   assign wr_en       = s1_adv && calc.hit;

   pcdm_store #(
      .CHANNELS (CHANNELS),
      .ADC_BITS (ADC_BITS),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_addr (IDX_W'(req_tdata[3:0])),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(s1_chan_ff)),
      .wr_data (s1_sample_ff),
      .rd_data (old_sample)
   );

   pcdm_calc #(
      .ADC_BITS (ADC_BITS)
   ) u_calc (
      .in_range    (s1_in_range),
      .sample      (s1_sample_ff),
      .old_sample  (old_sample),
      .threshold   (thresh_ff),
      .inverted    (s1_inv_ff),
      .lower_limit (s1_lo_ff),
      .upper_limit (s1_hi_ff),
      .result      (calc)
   );

   // Result register: load on a hit, drop once the beat is taken
   always_comb begin
      if (s1_adv && calc.hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_ctl_ff   <= s1_ctl_ff;
         rsp_value_ff <= calc.value;
         rsp_chan_ff  <= midi_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_chan_ff, rsp_value_ff, rsp_ctl_ff};

   a_write_needs_item: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (s1_valid_ff && s1_in_range))
      else $error("store written without a valid in-range item");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !s1_adv)
      else $error("stage 1 advanced into an occupied result register");

   a_value_in_limits: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((calc.value >= s1_lo_ff && calc.value <= s1_hi_ff) ||
                 (calc.value <= s1_lo_ff && calc.value >= s1_hi_ff) ||
                 (s1_lo_ff == '0 && s1_hi_ff == CC_MAX)))
      else $error("mapped value outside channel limits");

   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
